>>> design/fct_pkg.sv
package fct_pkg;

    localparam int IV_W      = 27;
    localparam int STAB_W    = 9;
    localparam int VB_W      = 30;
    localparam int DATA_W    = 32;
    localparam int QUO_W     = 8;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int N_VIDEO   = 5;

    localparam logic [IV_W-1:0]   IV_MIN        = 27'd2000000;
    localparam logic [IV_W-1:0]   IV_MAX        = 27'd100000000;
    localparam logic [IV_W-1:0]   STEP_FLOOR    = 27'd250000;
    localparam logic [STAB_W-1:0] STAB_RESET    = 9'd128;
    localparam logic [STAB_W-1:0] STAB_FULL     = 9'd256;
    localparam logic [STAB_W-1:0] STAB_STABLE   = 9'd224;
    localparam logic [STAB_W-1:0] STAB_UNSTABLE = 9'd64;
    localparam logic [IV_W-1:0]   TOL_FLOOR     = 27'd300000;
    localparam logic [VB_W-1:0]   PRED_FLOOR    = 30'd100000;
    localparam logic [VB_W-1:0]   VBLANK_RESET  = 30'd16666666;

    localparam logic [IV_W-1:0] VIDEO_PERIOD [N_VIDEO] = '{
        27'd16666666, 27'd20000000, 27'd33333333, 27'd40000000, 27'd41666666
    };

    localparam logic [1:0] CLS_HIGH     = 2'd0;
    localparam logic [1:0] CLS_VIDEO    = 2'd1;
    localparam logic [1:0] CLS_VARIABLE = 2'd2;
    localparam logic [1:0] CLS_UNSTABLE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_STAB,
        S_PRED,
        S_DONE
    } t_state;

    typedef struct packed {
        logic            start;
        logic [IV_W-1:0] num;
        logic [IV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    function automatic logic [IV_W-1:0] video_tol(input logic [IV_W-1:0] p);
        logic [IV_W-1:0] t;
        t = p >> 6;
        return (t < TOL_FLOOR) ? TOL_FLOOR : t;
    endfunction

endpackage

>>> design/fct_div.sv
module fct_div
    import fct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IV_W:0]    r_rem;
    logic [IV_W-1:0]  r_den;
    logic [QUO_W-1:0] r_quo;

    logic [IV_W:0]    n_rem_sh;
    logic             n_ge;

    // one restoring step per cycle; numerator is below the divisor on entry
    assign n_rem_sh = {r_rem[IV_W-1:0], 1'b0};
    assign n_ge     = n_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
            r_quo <= {r_quo[QUO_W-2:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> design/frame_cadence_tracker_core.sv
// One item at a time: a new interval is taken only in the idle state, after the previous
//   one has passed the prepare, divide, stability, prediction and done states.
// Out-of-range or first stored intervals skip the 8-step serial divider and the stability state.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low): stability 128, stored interval and prediction 0,
//   vblank period 16666666 ns, no result pending.
module frame_cadence_tracker_core
    import fct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VB_W-1:0]   i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_interval_ns,
    input  logic              i_render_valid,
    input  logic [DATA_W-1:0] i_render_ns,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAB_W-1:0] o_stability_level,
    output logic [DATA_W-1:0] o_predicted_render_ns,
    output logic [1:0]        o_cadence_class
);

    t_state r_state, n_state;

    logic [VB_W-1:0]   r_vblank;
    logic [IV_W-1:0]   r_last;
    logic [STAB_W-1:0] r_stab;
    logic [DATA_W-1:0] r_pred;
    logic [DATA_W-1:0] r_iv;
    logic              r_rv;
    logic [DATA_W-1:0] r_rn;
    logic              r_out_valid;
    logic [STAB_W-1:0] r_out_stab;
    logic [DATA_W-1:0] r_out_pred;
    logic [1:0]        r_out_cls;

    logic in_ready, do_prep, do_stab, do_pred, out_load;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // interval filter
    logic            n_out_range, n_first;
    logic [IV_W-1:0] n_iv, n_step, n_lo_raw, n_lo, n_hi, n_filt, n_diff;
    logic [IV_W:0]   n_hi_raw;

    assign n_out_range = (r_iv < {5'd0, IV_MIN}) || (r_iv > {5'd0, IV_MAX});
    assign n_first     = (r_last == '0);
    assign n_iv        = r_iv[IV_W-1:0];

    always_comb begin
        n_step   = r_last >> 1;
        if (n_step < STEP_FLOOR) n_step = STEP_FLOOR;
        n_lo_raw = (r_last > n_step) ? (r_last - n_step) : '0;
        n_lo     = (n_lo_raw < IV_MIN) ? IV_MIN : n_lo_raw;
        n_hi_raw = {1'b0, r_last} + {1'b0, n_step};
        n_hi     = (n_hi_raw > {1'b0, IV_MAX}) ? IV_MAX : n_hi_raw[IV_W-1:0];
        n_filt   = n_iv;
        if (n_filt < n_lo) n_filt = n_lo;
        if (n_filt > n_hi) n_filt = n_hi;
        n_diff   = (n_filt >= r_last) ? (n_filt - r_last) : (r_last - n_filt);
    end

    assign div_req.start = do_prep && !n_out_range && !n_first;
    assign div_req.num   = n_diff;
    assign div_req.den   = r_last;

    fct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // stability average: slow rise, fast fall
    logic [STAB_W-1:0] n_sample, n_stab;
    logic [11:0]       n_rise;
    logic [STAB_W:0]   n_fall;

    assign n_sample = STAB_FULL - {1'b0, div_rsp.quo};
    assign n_rise   = ({r_stab, 3'b000} - {3'b000, r_stab}) + {3'b000, n_sample};
    assign n_fall   = {1'b0, r_stab} + {1'b0, n_sample};
    assign n_stab   = (n_sample > r_stab) ? n_rise[11:3] : n_fall[STAB_W:1];

    // render prediction
    logic [10:0]       n_stab3;
    logic [2:0]        n_shift, n_shift_up;
    logic [DATA_W:0]   n_up_d, n_dn_d, n_mask, n_upd, n_upd_lo, n_upd_hi;
    logic [VB_W-1:0]   n_plo;
    logic [DATA_W-1:0] n_pred;

    always_comb begin
        n_stab3    = {2'b00, r_stab} + {1'b0, r_stab, 1'b0};
        n_shift    = n_stab3[10:8] + 3'd1;
        n_shift_up = (n_shift > 3'd2) ? 3'd2 : n_shift;
        n_mask     = ({{DATA_W{1'b0}}, 1'b1} << n_shift) - 1'b1;
        n_up_d     = ({1'b0, r_rn} - {1'b0, r_pred} + 1'b1) >> n_shift_up;
        n_dn_d     = ({1'b0, r_pred} - {1'b0, r_rn} + n_mask) >> n_shift;
        n_upd      = (r_rn > r_pred) ? ({1'b0, r_pred} + n_up_d)
                                     : ({1'b0, r_pred} - n_dn_d);
        n_plo      = r_vblank >> 5;
        if (n_plo < PRED_FLOOR) n_plo = PRED_FLOOR;
        n_upd_lo   = (n_upd < {3'b000, n_plo}) ? {3'b000, n_plo} : n_upd;
        n_upd_hi   = (n_upd_lo > {1'b0, r_vblank, 2'b00}) ? {1'b0, r_vblank, 2'b00}
                                                           : n_upd_lo;
        n_pred     = n_upd_hi[DATA_W-1:0];
    end

    // cadence class
    logic              n_video;
    logic [1:0]        n_cls;
    logic [IV_W-1:0]   n_vd;
    logic [DATA_W-1:0] n_vb3;

    always_comb begin
        n_video = 1'b0;
        for (int k = 0; k < N_VIDEO; k++) begin
            n_vd = (r_last >= VIDEO_PERIOD[k]) ? (r_last - VIDEO_PERIOD[k])
                                               : (VIDEO_PERIOD[k] - r_last);
            if (n_vd <= video_tol(VIDEO_PERIOD[k])) n_video = 1'b1;
        end
        n_vb3 = {2'b00, r_vblank} + {1'b0, r_vblank, 1'b0};
        if (r_last == '0 || r_vblank == '0) begin
            n_cls = CLS_VARIABLE;
        end else if (n_video && r_stab >= STAB_STABLE) begin
            n_cls = CLS_VIDEO;
        end else if ({4'd0, r_last, 1'b0} <= n_vb3) begin
            n_cls = CLS_HIGH;
        end else if (r_stab <= STAB_UNSTABLE && {5'd0, r_last} >= {r_vblank, 2'b00}) begin
            n_cls = CLS_UNSTABLE;
        end else begin
            n_cls = CLS_VARIABLE;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_PREP;
            S_PREP: n_state = (n_out_range || n_first) ? S_PRED : S_DIV;
            S_DIV:  if (div_rsp.done) n_state = S_STAB;
            S_STAB: n_state = S_PRED;
            S_PRED: n_state = S_DONE;
            S_DONE: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        do_prep  = 1'b0;
        do_stab  = 1'b0;
        do_pred  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_PREP: do_prep  = 1'b1;
            S_DIV:  ;
            S_STAB: do_stab  = 1'b1;
            S_PRED: do_pred  = 1'b1;
            S_DONE: out_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vblank    <= VBLANK_RESET;
            r_last      <= '0;
            r_stab      <= STAB_RESET;
            r_pred      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vblank <= i_cfg_wdata;
            if (do_prep) begin
                if (n_out_range) begin
                    r_stab <= STAB_RESET;
                    r_last <= '0;
                end else begin
                    r_last <= n_iv;
                end
            end
            if (do_stab) r_stab <= n_stab;
            if (do_pred && r_rv && r_rn != '0) begin
                r_pred <= (r_pred == '0) ? r_rn : n_pred;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_iv <= i_interval_ns;
            r_rv <= i_render_valid;
            r_rn <= i_render_ns;
        end
        if (out_load) begin
            r_out_stab <= r_stab;
            r_out_pred <= r_pred;
            r_out_cls  <= n_cls;
        end
    end

    assign o_ready               = in_ready;
    assign o_valid               = r_out_valid;
    assign o_stability_level     = r_out_stab;
    assign o_predicted_render_ns = r_out_pred;
    assign o_cadence_class       = r_out_cls;

    a_stab_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stab <= STAB_FULL)
        else $error("stability above full scale");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after input transfer");

    a_last_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last == '0) || (r_last >= IV_MIN && r_last <= IV_MAX))
        else $error("stored interval out of range");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

endmodule

>>> tb/cadence_checker.sv
`timescale 1ns / 100ps

module cadence_checker
    import fct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VB_W-1:0]   i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [DATA_W-1:0] i_interval_ns,
    input  logic              i_render_valid,
    input  logic [DATA_W-1:0] i_render_ns,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [STAB_W-1:0] i_stability_level,
    input  logic [DATA_W-1:0] i_predicted_render_ns,
    input  logic [1:0]        i_cadence_class,
    output int                o_mismatches,
    output int                o_outstanding
);

    typedef struct packed {
        logic [STAB_W-1:0] level;
        logic [DATA_W-1:0] render;
        logic [1:0]        cls;
    } t_frame_report;

    logic [63:0]   last_iv;
    logic [63:0]   stab;
    logic [63:0]   pred;
    logic [63:0]   vblank;
    t_frame_report reports_due [$];
    int            mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic track_frame(input logic [DATA_W-1:0] iv_in, input logic rv,
                               input logic [DATA_W-1:0] rn_in, output t_frame_report rep);
        logic [63:0] iv, prev, step, lo, hi, filt, diff, dev, sample;
        logic [63:0] m, cur, shift, upd, mag, p, tol, d;
        logic [1:0]  cls;
        logic        video;
        iv = {32'd0, iv_in};
        if (iv < 64'(IV_MIN) || iv > 64'(IV_MAX)) begin
            stab    = 64'(STAB_RESET);
            last_iv = 64'd0;
        end else begin
            prev    = last_iv;
            last_iv = iv;
            if (prev >= 64'(IV_MIN)) begin
                step = prev >> 1;
                if (step < 64'(STEP_FLOOR)) step = 64'(STEP_FLOOR);
                lo = (prev > step) ? prev - step : 64'd0;
                if (lo < 64'(IV_MIN)) lo = 64'(IV_MIN);
                hi = prev + step;
                if (hi > 64'(IV_MAX)) hi = 64'(IV_MAX);
                filt = iv;
                if (filt < lo) filt = lo;
                if (filt > hi) filt = hi;
                diff = (filt >= prev) ? filt - prev : prev - filt;
                dev = (diff << 8) / prev;
                if (dev > 64'd256) dev = 64'd256;
                sample = 64'd256 - dev;
                if (sample > stab) begin
                    stab = (stab * 64'd7 + sample) >> 3;
                end else begin
                    stab = (stab + sample) >> 1;
                end
            end
        end

        m = {32'd0, rn_in};
        if (rv && m != 64'd0) begin
            cur = pred;
            if (cur == 64'd0) begin
                pred = m;
            end else begin
                shift = 64'd1 + ((stab * 64'd3) >> 8);
                if (m > cur) begin
                    if (shift > 64'd2) shift = 64'd2;
                    upd = cur + ((m - cur + 64'd1) >> shift);
                end else begin
                    mag = cur - m;
                    upd = cur - ((mag + (64'd1 << shift) - 64'd1) >> shift);
                end
                lo = vblank >> 5;
                if (lo < 64'(PRED_FLOOR)) lo = 64'(PRED_FLOOR);
                hi = vblank << 2;
                if (upd < lo) upd = lo;
                if (upd > hi) upd = hi;
                pred = {32'd0, upd[31:0]};
            end
        end

        if (last_iv == 64'd0 || vblank == 64'd0) begin
            cls = CLS_VARIABLE;
        end else begin
            video = 1'b0;
            if (stab >= 64'(STAB_STABLE)) begin
                for (int k = 0; k < N_VIDEO; k++) begin
                    p = 64'(VIDEO_PERIOD[k]);
                    tol = p / 64'd64;
                    if (tol < 64'(TOL_FLOOR)) tol = 64'(TOL_FLOOR);
                    d = (last_iv >= p) ? last_iv - p : p - last_iv;
                    if (d <= tol) video = 1'b1;
                end
            end
            if (video) begin
                cls = CLS_VIDEO;
            end else if (last_iv <= (vblank * 64'd3) / 64'd2) begin
                cls = CLS_HIGH;
            end else if (stab <= 64'(STAB_UNSTABLE) && last_iv >= vblank * 64'd4) begin
                cls = CLS_UNSTABLE;
            end else begin
                cls = CLS_VARIABLE;
            end
        end

        rep.level  = stab[STAB_W-1:0];
        rep.render = pred[DATA_W-1:0];
        rep.cls    = cls;
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_report seen;
        t_frame_report due;
        if (!i_rst_n) begin
            last_iv = 64'd0;
            stab    = 64'(STAB_RESET);
            pred    = 64'd0;
            vblank  = 64'(VBLANK_RESET);
            reports_due.delete();
        end else begin
            if (i_cfg_we) vblank = {34'd0, i_cfg_wdata};
            if (i_out_valid && i_out_ready) begin
                seen.level  = i_stability_level;
                seen.render = i_predicted_render_ns;
                seen.cls    = i_cadence_class;
                if (reports_due.size() == 0) begin
                    report_mismatch("unexpected result, stability", 0, seen.level);
                end else begin
                    due = reports_due.pop_front();
                    if (seen.level !== due.level)
                        report_mismatch("stability_level", due.level, seen.level);
                    if (seen.render !== due.render)
                        report_mismatch("predicted_render_ns", due.render, seen.render);
                    if (seen.cls !== due.cls)
                        report_mismatch("cadence_class", due.cls, seen.cls);
                end
            end
            if (i_in_valid && i_in_ready) begin
                track_frame(i_interval_ns, i_render_valid, i_render_ns, due);
                reports_due.push_back(due);
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= reports_due.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench
    import fct_pkg::*;
();

    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_THIRD  = 3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [VB_W-1:0]   i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [DATA_W-1:0] i_interval_ns = '0;
    logic              i_render_valid = 1'b0;
    logic [DATA_W-1:0] i_render_ns = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [STAB_W-1:0] o_stability_level;
    logic [DATA_W-1:0] o_predicted_render_ns;
    logic [1:0]        o_cadence_class;

    int mismatches;
    int outstanding;

    int          burst_left = 0;
    int          cad_run = 0;
    logic [31:0] cad_base = 32'd16666666;
    logic [31:0] render_base = 32'd5000000;

    always #10 i_clk = ~i_clk;

    frame_cadence_tracker_core uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_interval_ns         (i_interval_ns),
        .i_render_valid        (i_render_valid),
        .i_render_ns           (i_render_ns),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_stability_level     (o_stability_level),
        .o_predicted_render_ns (o_predicted_render_ns),
        .o_cadence_class       (o_cadence_class)
    );

    cadence_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_in_valid            (i_valid),
        .i_in_ready            (o_ready),
        .i_interval_ns         (i_interval_ns),
        .i_render_valid        (i_render_valid),
        .i_render_ns           (i_render_ns),
        .i_out_valid           (o_valid),
        .i_out_ready           (i_ready),
        .i_stability_level     (o_stability_level),
        .i_predicted_render_ns (o_predicted_render_ns),
        .i_cadence_class       (o_cadence_class),
        .o_mismatches          (mismatches),
        .o_outstanding         (outstanding)
    );

    // called at a rising edge; returns at the edge of the transfer
    task automatic offer_frame(input logic [31:0] iv, input logic rv, input logic [31:0] rn);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(7, 0) == 0) ? 150 : $urandom_range(24, 1);
        end
        i_valid        <= 1'b1;
        i_interval_ns  <= iv;
        i_render_valid <= rv;
        i_render_ns    <= rn;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (16) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_vblank(input logic [VB_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic pick_frame(output logic [31:0] iv, output logic rv, output logic [31:0] rn);
        int          sel;
        logic [31:0] amp;
        if (cad_run == 0) begin
            case ($urandom_range(3, 0))
                0: cad_base = 32'(VIDEO_PERIOD[$urandom_range(N_VIDEO - 1, 0)]);
                1: cad_base = $urandom_range(100000000, 2000000);
                2: cad_base = $urandom_range(30000000, 2000000);
                default: cad_base = $urandom_range(100000000, 60000000);
            endcase
            cad_run     = $urandom_range(40, 3);
            render_base = $urandom_range(50000000, 100000);
        end
        cad_run--;
        sel = $urandom_range(99, 0);
        if (sel < 80) begin
            amp = cad_base >> $urandom_range(14, 4);
            iv  = cad_base - amp + $urandom_range(2 * amp, 0);
        end else if (sel < 86) begin
            iv = $urandom_range(2000001, 0);
        end else if (sel < 90) begin
            iv = $urandom_range(100000000, 2000000);
        end else if (sel < 95) begin
            iv = $urandom_range(120000000, 99999999);
        end else begin
            iv = $urandom;
        end
        rv  = ($urandom_range(3, 0) != 0);
        sel = $urandom_range(99, 0);
        if (sel < 75) begin
            rn = render_base - render_base / 8 + $urandom_range(render_base / 4, 0);
        end else if (sel < 80) begin
            rn = 32'd0;
        end else if (sel < 90) begin
            rn = $urandom_range(200000, 0);
        end else begin
            rn = $urandom;
        end
    endtask

    initial begin : receiver
        int served;
        int hold_left;
        int hold_mark;
        int mode;
        int mode_left;
        int phase;
        served    = 0;
        hold_left = 0;
        hold_mark = 150;
        mode      = RX_OPEN;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) served++;
            if (hold_left == 0 && served >= hold_mark) begin
                hold_left = 400;
                hold_mark += 270;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_THIRD, RX_OPEN);
                    mode_left = $urandom_range(80, 10);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= ($urandom_range(1, 0) == 1);
                    RX_SPARSE: i_ready <= ($urandom_range(3, 0) == 0);
                    default:   i_ready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [31:0]     iv;
        logic [31:0]     rn;
        logic            rv;
        logic [VB_W-1:0] vb_list [6];
        vb_list[0] = 30'd1000000;
        vb_list[1] = 30'h3FFFFFFF;
        vb_list[2] = 30'd0;
        vb_list[3] = VBLANK_RESET;
        vb_list[4] = VB_W'($urandom_range(1000000000, 1000000));
        vb_list[5] = 30'd8333333;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of range, zero render, unclamped seed, range edges
        offer_frame(32'd0, 1'b1, 32'd0);
        offer_frame(32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
        offer_frame(32'd1999999, 1'b1, 32'd1);
        offer_frame(32'd2000000, 1'b0, 32'd5000000);
        offer_frame(32'd100000000, 1'b1, 32'hFFFFFFFF);
        offer_frame(32'd100000001, 1'b1, 32'd7000000);
        // steady 60 Hz run, stability climbs into video class
        for (int k = 0; k < 12; k++) begin
            offer_frame(32'd16666666, k[0], (k == 3) ? 32'd0 : 32'd8000000 + k * 32'd100000);
        end
        offer_frame(32'd33333333, 1'b1, 32'd200000000);
        offer_frame(32'd20000000, 1'b1, 32'd3000000);
        offer_frame(32'd40000000, 1'b1, 32'd9000000);
        offer_frame(32'd41666666, 1'b0, 32'd0);
        offer_frame(32'd10000000, 1'b1, 32'd6000000);
        offer_frame(32'd2000000, 1'b1, 32'd6000000);
        offer_frame(32'd100000000, 1'b1, 32'd1);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_vblank(vb_list[ph]);
            for (int n = 0; n < 100; n++) begin
                pick_frame(iv, rv, rn);
                offer_frame(iv, rv, rn);
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
design/fct_pkg.sv
design/fct_div.sv
design/frame_cadence_tracker_core.sv
tb/cadence_checker.sv
tb/testbench.sv
